// File: hdl/cclfp_pkg.sv
// package for the control code and length frame parser
// result kinds, link byte codes and the result word type; no dependencies
`timescale 1ns / 1ps

package cclfp_pkg;

  localparam logic [3:0] KIND_FREE       = 4'd0;
  localparam logic [3:0] KIND_SENDING    = 4'd1;
  localparam logic [3:0] KIND_DONE       = 4'd2;
  localparam logic [3:0] KIND_BUSY       = 4'd3;
  localparam logic [3:0] KIND_END        = 4'd4;
  localparam logic [3:0] KIND_HELLO      = 4'd5;
  localparam logic [3:0] KIND_TOKEN_OK   = 4'd6;
  localparam logic [3:0] KIND_TOKEN_REJ  = 4'd7;
  localparam logic [3:0] KIND_DATA       = 4'd8;
  localparam logic [3:0] KIND_DATA_SHORT = 4'd9;

  localparam logic [7:0] CODE_FREE       = 8'h01;
  localparam logic [7:0] CODE_BUSY       = 8'h02;
  localparam logic [7:0] CODE_OPEN       = 8'h03;
  localparam logic [7:0] CODE_SENDING    = 8'h04;
  localparam logic [7:0] CODE_DONE       = 8'h05;
  localparam logic [7:0] CODE_OPEN_SHORT = 8'h06;
  localparam logic [7:0] CODE_END        = 8'h08;
  localparam logic [7:0] CODE_HELLO      = 8'h09;
  localparam logic [7:0] CODE_TOKEN_OK   = 8'h0A;
  localparam logic [7:0] CODE_TOKEN_REJ  = 8'h0B;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_last;
  } result_t;

endpackage

// File: hdl/cclfp_parser.sv
// frame state and per-byte decode for the control code and length frame parser
// depends on cclfp_pkg
`timescale 1ns / 1ps

module cclfp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output cclfp_pkg::result_t  res
);
  import cclfp_pkg::*;

  logic       in_frame, in_frame_next;
  logic       length_known, length_known_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic       short_frame, short_frame_next;
  logic [7:0] seen_inc;
  logic [3:0] data_kind;

  assign seen_inc  = bytes_seen + 8'd1;
  assign data_kind = short_frame ? KIND_DATA_SHORT : KIND_DATA;

  always_comb begin
    in_frame_next     = in_frame;
    length_known_next = length_known;
    frame_length_next = frame_length;
    bytes_seen_next   = bytes_seen;
    short_frame_next  = short_frame;
    res_valid         = 1'b0;
    res.kind          = KIND_FREE;
    res.payload_byte  = 8'd0;
    res.has_byte      = 1'b0;
    res.frame_last    = 1'b1;
    if (!in_frame) begin
      unique case (rx_byte) inside
        CODE_FREE:      begin res_valid = 1'b1; res.kind = KIND_FREE;      end
        CODE_SENDING:   begin res_valid = 1'b1; res.kind = KIND_SENDING;   end
        CODE_DONE:      begin res_valid = 1'b1; res.kind = KIND_DONE;      end
        CODE_BUSY:      begin res_valid = 1'b1; res.kind = KIND_BUSY;      end
        CODE_END:       begin res_valid = 1'b1; res.kind = KIND_END;       end
        CODE_HELLO:     begin res_valid = 1'b1; res.kind = KIND_HELLO;     end
        CODE_TOKEN_OK:  begin res_valid = 1'b1; res.kind = KIND_TOKEN_OK;  end
        CODE_TOKEN_REJ: begin res_valid = 1'b1; res.kind = KIND_TOKEN_REJ; end
        CODE_OPEN, CODE_OPEN_SHORT: begin
          in_frame_next     = 1'b1;
          length_known_next = 1'b0;
          frame_length_next = 8'd0;
          bytes_seen_next   = 8'd0;
          short_frame_next  = (rx_byte == CODE_OPEN_SHORT);
        end
        default: begin
        end
      endcase
    end else if (!length_known) begin
      length_known_next = 1'b1;
      frame_length_next = rx_byte;
      bytes_seen_next   = 8'd0;
      if (rx_byte == 8'd0) begin
        in_frame_next     = 1'b0;
        length_known_next = 1'b0;
        res_valid         = 1'b1;
        res.kind          = data_kind;
      end
    end else begin
      bytes_seen_next  = seen_inc;
      res_valid        = 1'b1;
      res.kind         = data_kind;
      res.payload_byte = rx_byte;
      res.has_byte     = 1'b1;
      res.frame_last   = (seen_inc == frame_length);
      if (seen_inc == frame_length) begin
        in_frame_next     = 1'b0;
        length_known_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      length_known <= 1'b0;
      frame_length <= 8'd0;
      bytes_seen   <= 8'd0;
      short_frame  <= 1'b0;
    end else if (fire) begin
      in_frame     <= in_frame_next;
      length_known <= length_known_next;
      frame_length <= frame_length_next;
      bytes_seen   <= bytes_seen_next;
      short_frame  <= short_frame_next;
    end
  end

  a_known_in_frame: assert property (@(posedge clk) disable iff (rst)
    length_known |-> in_frame)
    else $error("length known outside a frame");

  a_count_below_length: assert property (@(posedge clk) disable iff (rst)
    length_known |-> (frame_length != 8'd0) && (bytes_seen < frame_length))
    else $error("payload count reached frame length without closing");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && !res.has_byte) |-> res.frame_last)
    else $error("result without a byte not marked last");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.has_byte && res.frame_last) |=> !in_frame)
    else $error("last payload word did not close the frame");

endmodule

// File: hdl/control_code_and_length_frame_parser.sv
// top level of the control code and length frame parser
// input register, parser and result register; depends on cclfp_pkg and cclfp_parser
`timescale 1ns / 1ps

// Accepts one link byte per cycle while in_ready is high and returns at most
// one result word for it. A byte is held in the input register, where the
// parser decodes it against the frame state, and the result is then captured
// in the result register when that register is free, and leaves from there.
// The frame state updates as each byte advances, for a rate of one byte per
// clock when not stalled; a stalled result register holds the input register,
// and input ready falls only when both are full. Bytes that give no result
// (unknown codes, frame openers, nonzero length bytes) yield no output word.
module control_code_and_length_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] kind,
  output logic [7:0] payload_byte,
  output logic       has_byte,
  output logic       frame_last
);
  import cclfp_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       res_valid;
  result_t    res;
  result_t    out_word;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = hold_valid && (!res_valid || out_free);
  assign in_ready = !hold_valid || advance;

  cclfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .rx_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && res_valid) begin
      out_word <= res;
    end
  end

  assign kind         = out_word.kind;
  assign payload_byte = out_word.payload_byte;
  assign has_byte     = out_word.has_byte;
  assign frame_last   = out_word.frame_last;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !advance) |=> hold_valid && $stable(hold_byte))
    else $error("held word lost while result register stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && res_valid))
    else $error("result produced into a full result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> in_ready)
    else $error("input not ready with an empty input register");

endmodule

// File: sim/tb_control_code_and_length_frame_parser.sv
// testbench for control_code_and_length_frame_parser: directed and random link bytes
// with random bursts, gaps and output stalls, every result word checked against a
// local frame parser model; depends on cclfp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_control_code_and_length_frame_parser;

  import cclfp_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] kind;
  logic [7:0] payload_byte;
  logic       has_byte;
  logic       frame_last;

  control_code_and_length_frame_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .has_byte     (has_byte),
    .frame_last   (frame_last)
  );

  always #1 clk = ~clk;

  logic [7:0] link_bytes [$];
  result_t    expected_words [$];

  // frame state of the local parser
  logic       fr_open = 1'b0;
  logic       fr_len_known = 1'b0;
  logic [7:0] fr_len = 8'h00;
  logic [7:0] fr_seen = 8'h00;
  logic       fr_short = 1'b0;

  logic [7:0] ctrl_codes [8] = '{CODE_FREE, CODE_SENDING, CODE_DONE, CODE_BUSY,
                                 CODE_END, CODE_HELLO, CODE_TOKEN_OK, CODE_TOKEN_REJ};

  int unsigned fail_cnt = 0;
  int unsigned bytes_in = 0;
  int unsigned words_out = 0;
  int unsigned ctrl_words = 0;
  int unsigned data_words = 0;
  int unsigned frames_closed = 0;

  bit          word_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  phase = 8'h00;

  result_t     exp_w;

  task automatic parse_link_byte(input logic [7:0] b);
    result_t w;
    w = '0;
    if (!fr_open) begin
      w.frame_last = 1'b1;
      case (b) inside
        CODE_FREE:      w.kind = KIND_FREE;
        CODE_SENDING:   w.kind = KIND_SENDING;
        CODE_DONE:      w.kind = KIND_DONE;
        CODE_BUSY:      w.kind = KIND_BUSY;
        CODE_END:       w.kind = KIND_END;
        CODE_HELLO:     w.kind = KIND_HELLO;
        CODE_TOKEN_OK:  w.kind = KIND_TOKEN_OK;
        CODE_TOKEN_REJ: w.kind = KIND_TOKEN_REJ;
        CODE_OPEN, CODE_OPEN_SHORT: begin
          fr_open = 1'b1;
          fr_len_known = 1'b0;
          fr_len = 8'h00;
          fr_seen = 8'h00;
          fr_short = (b == CODE_OPEN_SHORT);
          return;
        end
        default: return;
      endcase
      expected_words = {expected_words, w};
      return;
    end
    w.kind = fr_short ? KIND_DATA_SHORT : KIND_DATA;
    if (!fr_len_known) begin
      fr_len_known = 1'b1;
      fr_len = b;
      fr_seen = 8'h00;
      // zero length closes the frame with an empty word
      if (b == 8'h00) begin
        fr_open = 1'b0;
        fr_len_known = 1'b0;
        w.frame_last = 1'b1;
        expected_words = {expected_words, w};
      end
      return;
    end
    fr_seen = fr_seen + 8'd1;
    w.payload_byte = b;
    w.has_byte = 1'b1;
    if (fr_seen == fr_len) begin
      fr_open = 1'b0;
      fr_len_known = 1'b0;
      w.frame_last = 1'b1;
    end
    expected_words = {expected_words, w};
  endtask

  task automatic queue_frame(input logic [7:0] opener, input logic [7:0] len,
                             input int unsigned n_pay);
    logic [7:0] b;
    link_bytes = {link_bytes, opener};
    link_bytes = {link_bytes, len};
    for (int unsigned i = 0; i < n_pay; i++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 5) == 0) b = ctrl_codes[$urandom_range(0, 7)];
      link_bytes = {link_bytes, b};
    end
  endtask

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !word_taken) begin
      in_valid <= 1'b1;
    end else begin
      word_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (link_bytes.size() > 0) begin
        in_valid <= 1'b1;
        rx_byte <= link_bytes[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      parse_link_byte(rx_byte);
      void'(link_bytes.pop_front());
      word_taken = 1'b1;
      bytes_in++;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_in >= 400) begin
      hold_done = 1'b1;
      hold_left = 299;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase = phase + 8'd1;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= phase[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d payload_byte %0h has_byte %0b frame_last %0b",
               kind, payload_byte, has_byte, frame_last);
        fail_cnt++;
      end else begin
        exp_w = expected_words.pop_front();
        if (kind !== exp_w.kind) begin
          $error("kind: expected %0d, actual %0d", exp_w.kind, kind);
          fail_cnt++;
        end
        if (payload_byte !== exp_w.payload_byte) begin
          $error("payload_byte: expected %0h, actual %0h", exp_w.payload_byte, payload_byte);
          fail_cnt++;
        end
        if (has_byte !== exp_w.has_byte) begin
          $error("has_byte: expected %0b, actual %0b", exp_w.has_byte, has_byte);
          fail_cnt++;
        end
        if (frame_last !== exp_w.frame_last) begin
          $error("frame_last: expected %0b, actual %0b", exp_w.frame_last, frame_last);
          fail_cnt++;
        end
        words_out++;
        if (exp_w.kind >= KIND_DATA) begin
          data_words++;
          if (exp_w.frame_last) frames_closed++;
        end else begin
          ctrl_words++;
        end
      end
    end
  end

  initial begin
    logic [7:0]  directed [26];
    logic [7:0]  b;
    logic [7:0]  opener;
    int unsigned sel;
    int unsigned len;
    int unsigned drain_cycles;

    directed = '{CODE_FREE, CODE_SENDING, CODE_DONE, CODE_BUSY, CODE_END, CODE_HELLO,
                 CODE_TOKEN_OK, CODE_TOKEN_REJ, 8'h00, 8'hFF, 8'h07, 8'h0C,
                 CODE_OPEN, 8'h00, CODE_OPEN_SHORT, 8'h00,
                 CODE_OPEN, 8'h01, 8'hFF,
                 CODE_OPEN_SHORT, 8'h04, CODE_OPEN, CODE_FREE, CODE_OPEN_SHORT, 8'h00,
                 CODE_TOKEN_REJ};
    foreach (directed[i]) link_bytes = {link_bytes, directed[i]};

    queue_frame(CODE_OPEN, 8'hFF, 255);
    while (link_bytes.size() < 2000) begin
      sel = $urandom_range(0, 99);
      opener = (sel < 35) ? CODE_OPEN : CODE_OPEN_SHORT;
      if (sel < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
        queue_frame(opener, 8'(len), len);
      end else if (sel < 75) begin
        link_bytes = {link_bytes, ctrl_codes[$urandom_range(0, 7)]};
      end else if (sel < 85) begin
        b = 8'($urandom);
        if (b >= CODE_FREE && b <= CODE_TOKEN_REJ && b != 8'h07) b[7] = 1'b1;
        link_bytes = {link_bytes, b};
      end else if (sel < 92) begin
        // truncated frame, following bytes land in its payload
        len = $urandom_range(2, 12);
        queue_frame(($urandom_range(0, 1) == 0) ? CODE_OPEN : CODE_OPEN_SHORT, 8'(len),
                    $urandom_range(0, len - 1));
      end else begin
        b = 8'($urandom);
        link_bytes = {link_bytes, b};
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (link_bytes.size() > 0 || in_valid) @(posedge clk);
    drain_cycles = 0;
    while (expected_words.size() > 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_words.size() > 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_cnt++;
    end

    $display("sent %0d link bytes, checked %0d words (%0d control, %0d data)",
             bytes_in, words_out, ctrl_words, data_words);
    $display("%0d data frames closed, one long output stall applied", frames_closed);
    if (fail_cnt == 0) begin
      $display("control_code_and_length_frame_parser: match");
    end else begin
      $display("control_code_and_length_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("control_code_and_length_frame_parser: mismatch");
    $finish;
  end

endmodule
